@@ sv/ecot_pkg.sv @@
// Shared constants, widths and polygon coefficient tables for the overlap test.
package ecot_pkg;

   localparam int COORD_WIDTH    = 24;
   localparam int MAX_ITERATIONS = 4;
   localparam int COEF_SHIFT     = 30;
   localparam int HW             = 28;
   localparam int OW             = 2 * HW + 1;
   localparam int AW             = 120;
   localparam int PW             = 28;

   typedef logic [COEF_SHIFT-1:0] coef_type;

   function automatic coef_type inner_coef(input logic [2:0] idx);
      coef_type c;
      case (idx)
         3'd0:    c = coef_type'(759250125);
         3'd1:    c = coef_type'(581104888);
         3'd2:    c = coef_type'(547388835);
         3'd3:    c = coef_type'(539468601);
         3'd4:    c = coef_type'(537518376);
         3'd5:    c = coef_type'(537032656);
         3'd6:    c = coef_type'(536911340);
         default: c = coef_type'(536881019);
      endcase
      return c;
   endfunction

   function automatic coef_type outer_coef(input logic [2:0] idx);
      coef_type c;
      case (idx)
         3'd0:    c = coef_type'(628983398);
         3'd1:    c = coef_type'(558112816);
         3'd2:    c = coef_type'(542078859);
         3'd3:    c = coef_type'(538166622);
         3'd4:    c = coef_type'(537194449);
         3'd5:    c = coef_type'(536951772);
         3'd6:    c = coef_type'(536891125);
         default: c = coef_type'(536875965);
      endcase
      return c;
   endfunction

endpackage

@@ sv/ecot_if.sv @@
// Request and response channel interfaces of the overlap test.
interface ecot_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ecot_pkg::COORD_WIDTH-1:0] ellipse_x;
   logic signed [ecot_pkg::COORD_WIDTH-1:0] ellipse_y;
   logic        [ecot_pkg::COORD_WIDTH-2:0] half_width;
   logic        [ecot_pkg::COORD_WIDTH-2:0] half_height;
   logic signed [ecot_pkg::COORD_WIDTH-1:0] circle_x;
   logic signed [ecot_pkg::COORD_WIDTH-1:0] circle_y;
   logic        [ecot_pkg::COORD_WIDTH-2:0] radius;

   modport source (output valid, ellipse_x, ellipse_y, half_width, half_height,
                   circle_x, circle_y, radius, input ready);
   modport sink   (input valid, ellipse_x, ellipse_y, half_width, half_height,
                   circle_x, circle_y, radius, output ready);
endinterface

interface ecot_rsp_if;
   logic valid;
   logic ready;
   logic overlap;

   modport source (output valid, overlap, input ready);
   modport sink   (input valid, overlap, output ready);
endinterface

@@ sv/ecot_mac.sv @@
// Shared two-term multiply-accumulate unit: base + a*b + c*d.
module ecot_mac (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [ecot_pkg::AW-1:0]   base,
   input  logic signed [ecot_pkg::OW-1:0]   a,
   input  logic signed [ecot_pkg::OW-1:0]   b,
   input  logic signed [ecot_pkg::OW-1:0]   c,
   input  logic signed [ecot_pkg::OW-1:0]   d,
   output logic                             done,
   output logic signed [ecot_pkg::AW-1:0]   acc
);
   import ecot_pkg::*;

   function automatic logic [2*HW-1:0] mag(input logic signed [OW-1:0] v);
      logic signed [OW-1:0] n;
      n = -v;
      return v[OW-1] ? n[2*HW-1:0] : v[2*HW-1:0];
   endfunction

   logic [2*HW-1:0]       ma_ff, mb_ff, mc_ff, md_ff;
   logic                  na_ff, nc_ff;
   logic [2:0]            cnt_ff;
   logic                  busy_ff, done_ff;
   logic signed [AW-1:0]  acc_ff, acc_in;
   logic [2*HW-1:0]       xa, xb;
   logic [HW-1:0]         pa, pb;
   logic [2*HW-1:0]       pp;
   logic [AW-1:0]         ext;

   always_comb begin
      xa = cnt_ff[2] ? mc_ff : ma_ff;
      xb = cnt_ff[2] ? md_ff : mb_ff;
      pa = cnt_ff[1] ? xa[2*HW-1:HW] : xa[HW-1:0];
      pb = cnt_ff[0] ? xb[2*HW-1:HW] : xb[HW-1:0];
      pp = pa * pb;
      case (cnt_ff[1:0])
         2'b00:   ext = AW'(pp);
         2'b11:   ext = AW'(pp) << (2 * HW);
         default: ext = AW'(pp) << HW;
      endcase
      if (cnt_ff[2] ? nc_ff : na_ff) begin
         acc_in = acc_ff - signed'(ext);
      end else begin
         acc_in = acc_ff + signed'(ext);
      end
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (start) begin
         acc_ff  <= base;
         ma_ff   <= mag(a);
         mb_ff   <= mag(b);
         mc_ff   <= mag(c);
         md_ff   <= mag(d);
         na_ff   <= a[OW-1] ^ b[OW-1];
         nc_ff   <= c[OW-1] ^ d[OW-1];
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

@@ sv/ellipse_circle_overlap_test.sv @@
// Top level of the ellipse / circle overlap test: sequencer around the shared MAC.
//
// Usage:
//   req carries one axis-aligned ellipse (centre, half-axes) and one circle
//   (centre, radius), signed fixed point with 12 fractional bits. rsp returns
//   one overlap flag per request. A transfer happens when valid and ready are
//   both high at a rising clock edge.
//   One request is worked on at a time: req.ready is high only while idle.
//   Every arithmetic step is a two-term multiply-accumulate on the single shared
//   MAC unit; each step starts it, forms 8 partial products of 28 x 28 bits
//   and finishes. The quick tests take 4 to 10 steps, and each refinement
//   round takes 3 to 20 steps.
//   The result is held in rsp until it is taken; a stalled receiver holds the
//   block, and the next request is accepted the cycle after the response transfer.
//   Synchronous reset returns the sequencer to idle and drops rsp.valid; no
//   other state needs clearing.
module ellipse_circle_overlap_test (
   input logic  clock,
   input logic  reset,
   ecot_req_if.sink   req,
   ecot_rsp_if.source rsp
);
   import ecot_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE, S_RR, S_WW, S_HH, S_V1, S_V2, S_D1, S_D2, S_S, S_DC, S_CORNER,
      R_C1X, R_C1Y, R_T, R_ADOT, R_ALEN, R_ACR, R_ACMP, R_BDOT, R_BLEN, R_BCR,
      R_BCMP, R_C3X, R_C3Y, R_D3, R_D4, R_ELEN, R_ECR, R_ECMP, R_EDOT, R_F, R_G,
      S_OUT
   } state_type;

   localparam logic [2:0] LAST_ROUND = 3'(MAX_ITERATIONS - 1);

   state_type state_ff, last_ff;
   logic      result_ff;
   logic [2:0] t_ff;

   logic signed [PW-1:0] x_ff, y_ff, w_ff, h_ff, r_ff;
   logic signed [PW-1:0] c0x_ff, c0y_ff, c1x_ff, c1y_ff, c2x_ff, c2y_ff, c3x_ff, c3y_ff;
   logic signed [OW-1:0] rr_ff, ww_ff, hh_ff, s_ff, dot_ff, len_ff, cr_ff, d_ff;

   logic signed [OW-1:0] xo, yo, wo, ho, ro, c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;
   logic signed [OW-1:0] c4x, c4y, tx, ty, den;
   logic signed [AW-1:0] nrr;

   logic signed [OW-1:0] op_a, op_b, op_c, op_d;
   logic signed [AW-1:0] op_base, mac_acc, sc_mag, sc_q, sc;
   logic                 mac_start, mac_done;
   logic                 acc_le0, acc_lt0, near_edge;

   logic signed [COORD_WIDTH:0] dx, dy;

   assign xo  = OW'(x_ff);
   assign yo  = OW'(y_ff);
   assign wo  = OW'(w_ff);
   assign ho  = OW'(h_ff);
   assign ro  = OW'(r_ff);
   assign c0x = OW'(c0x_ff);
   assign c0y = OW'(c0y_ff);
   assign c1x = OW'(c1x_ff);
   assign c1y = OW'(c1y_ff);
   assign c2x = OW'(c2x_ff);
   assign c2y = OW'(c2y_ff);
   assign c3x = OW'(c3x_ff);
   assign c3y = OW'(c3y_ff);
   assign c4x = c1x + c1x - c3x;
   assign c4y = c1y + c1y - c3y;
   assign tx  = xo - c1x;
   assign ty  = yo - c1y;
   assign den = ww_ff + hh_ff;
   assign nrr = -AW'(rr_ff);

   assign dx = (COORD_WIDTH+1)'(req.circle_x) - (COORD_WIDTH+1)'(req.ellipse_x);
   assign dy = (COORD_WIDTH+1)'(req.circle_y) - (COORD_WIDTH+1)'(req.ellipse_y);

   assign acc_le0 = (mac_acc <= 0);
   assign acc_lt0 = mac_acc[AW-1];
   assign near_edge = ((xo <= wo) && (yo - ro <= ho)) || ((yo <= ho) && (xo - ro <= wo));

   // midpoint scaling, truncated toward zero
   assign sc_mag = mac_acc[AW-1] ? -mac_acc : mac_acc;
   assign sc_q   = sc_mag >>> COEF_SHIFT;
   assign sc     = mac_acc[AW-1] ? -sc_q : sc_q;

   assign mac_start = (state_ff != last_ff) && (state_ff != S_IDLE) && (state_ff != S_OUT);

   always_comb begin
      op_a = '0; op_b = '0; op_c = '0; op_d = '0; op_base = '0;
      unique case (state_ff)
         S_RR:     begin op_a = ro; op_b = ro; end
         S_WW:     begin op_a = wo; op_b = wo; end
         S_HH:     begin op_a = ho; op_b = ho; end
         S_V1:     begin
            op_a = xo; op_b = xo; op_c = ho - yo; op_d = ho - yo; op_base = nrr;
         end
         S_V2:     begin
            op_a = wo - xo; op_b = wo - xo; op_c = yo; op_d = yo; op_base = nrr;
         end
         S_D1:     begin op_a = xo; op_b = ho; op_c = yo; op_d = wo; end
         S_D2:     begin op_a = -wo; op_b = ho; op_base = mac_acc; end
         S_S:      begin op_a = xo; op_b = wo; op_c = -yo; op_d = ho; end
         S_DC:     begin op_a = d_ff; op_b = d_ff; op_c = -rr_ff; op_d = den; end
         S_CORNER: begin
            op_a = xo - wo; op_b = xo - wo; op_c = yo - ho; op_d = yo - ho; op_base = nrr;
         end
         R_C1X:    begin op_a = c0x + c2x; op_b = OW'(inner_coef(t_ff)); end
         R_C1Y:    begin op_a = c0y + c2y; op_b = OW'(inner_coef(t_ff)); end
         R_T:      begin op_a = tx; op_b = tx; op_c = ty; op_d = ty; op_base = nrr; end
         R_ADOT:   begin op_a = tx; op_b = c2x - c1x; op_c = ty; op_d = c2y - c1y; end
         R_ALEN:   begin
            op_a = c2x - c1x; op_b = c2x - c1x; op_c = c2y - c1y; op_d = c2y - c1y;
         end
         R_ACR:    begin op_a = ty; op_b = c2x - c1x; op_c = -tx; op_d = c2y - c1y; end
         R_BDOT:   begin op_a = tx; op_b = c0x - c1x; op_c = ty; op_d = c0y - c1y; end
         R_BLEN:   begin
            op_a = c0x - c1x; op_b = c0x - c1x; op_c = c0y - c1y; op_d = c0y - c1y;
         end
         R_BCR:    begin op_a = ty; op_b = c0x - c1x; op_c = -tx; op_d = c0y - c1y; end
         R_ACMP, R_BCMP, R_ECMP: begin
            op_a = cr_ff; op_b = cr_ff; op_c = -rr_ff; op_d = len_ff;
         end
         R_C3X:    begin op_a = c0x + c1x; op_b = OW'(outer_coef(t_ff)); end
         R_C3Y:    begin op_a = c0y + c1y; op_b = OW'(outer_coef(t_ff)); end
         R_D3:     begin
            op_a = c3x - xo; op_b = c3x - xo; op_c = c3y - yo; op_d = c3y - yo;
            op_base = nrr;
         end
         R_D4:     begin
            op_a = c4x - xo; op_b = c4x - xo; op_c = c4y - yo; op_d = c4y - yo;
            op_base = nrr;
         end
         R_ELEN:   begin
            op_a = c3x - c1x; op_b = c3x - c1x; op_c = c3y - c1y; op_d = c3y - c1y;
         end
         R_ECR:    begin op_a = ty; op_b = c3x - c1x; op_c = -tx; op_d = c3y - c1y; end
         R_EDOT:   begin op_a = tx; op_b = c3x - c1x; op_c = ty; op_d = c3y - c1y; end
         R_F:      begin
            op_a = xo - c3x; op_b = c0x - c3x; op_c = yo - c3y; op_d = c0y - c3y;
         end
         R_G:      begin
            op_a = xo - c4x; op_b = c2x - c4x; op_c = yo - c4y; op_d = c2y - c4y;
         end
         default: ;
      endcase
   end

   ecot_mac u_mac (
      .clock (clock),
      .reset (reset),
      .start (mac_start),
      .base  (op_base),
      .a     (op_a),
      .b     (op_b),
      .c     (op_c),
      .d     (op_d),
      .done  (mac_done),
      .acc   (mac_acc)
   );

   always_ff @(posedge clock) begin
      last_ff <= state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               x_ff     <= PW'(dx[COORD_WIDTH] ? -dx : dx);
               y_ff     <= PW'(dy[COORD_WIDTH] ? -dy : dy);
               w_ff     <= PW'({1'b0, req.half_width});
               h_ff     <= PW'({1'b0, req.half_height});
               r_ff     <= PW'({1'b0, req.radius});
               state_ff <= S_RR;
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               state_ff <= S_IDLE;
            end
         end
         default: begin
            if (mac_done) begin
               unique case (state_ff)
                  S_RR: begin rr_ff <= OW'(mac_acc); state_ff <= S_WW; end
                  S_WW: begin ww_ff <= OW'(mac_acc); state_ff <= S_HH; end
                  S_HH: begin hh_ff <= OW'(mac_acc); state_ff <= S_V1; end
                  S_V1, S_V2, R_T: begin
                     if (acc_le0) begin
                        result_ff <= 1'b1;
                        state_ff  <= S_OUT;
                     end else begin
                        state_ff <= (state_ff == S_V1) ? S_V2 :
                                    (state_ff == S_V2) ? S_D1 : R_ADOT;
                     end
                  end
                  S_D1: state_ff <= S_D2;
                  S_D2: begin
                     d_ff <= OW'(mac_acc);
                     if (acc_le0) begin
                        result_ff <= 1'b1;
                        state_ff  <= S_OUT;
                     end else begin
                        state_ff <= S_S;
                     end
                  end
                  S_S: begin s_ff <= OW'(mac_acc); state_ff <= S_DC; end
                  S_DC: begin
                     if (acc_le0 && (s_ff >= -hh_ff) && (s_ff <= ww_ff)) begin
                        result_ff <= 1'b1;
                        state_ff  <= S_OUT;
                     end else begin
                        state_ff <= S_CORNER;
                     end
                  end
                  S_CORNER: begin
                     if (acc_le0 || near_edge) begin
                        c0x_ff   <= w_ff;
                        c0y_ff   <= '0;
                        c2x_ff   <= '0;
                        c2y_ff   <= h_ff;
                        t_ff     <= '0;
                        state_ff <= R_C1X;
                     end else begin
                        result_ff <= 1'b0;
                        state_ff  <= S_OUT;
                     end
                  end
                  R_C1X: begin c1x_ff <= PW'(sc); state_ff <= R_C1Y; end
                  R_C1Y: begin c1y_ff <= PW'(sc); state_ff <= R_T; end
                  R_ADOT: begin dot_ff <= OW'(mac_acc); state_ff <= R_ALEN; end
                  R_ALEN: begin len_ff <= OW'(mac_acc); state_ff <= R_ACR; end
                  R_ACR:  begin cr_ff  <= OW'(mac_acc); state_ff <= R_ACMP; end
                  R_ACMP: begin
                     if (!dot_ff[OW-1] && (dot_ff <= len_ff) && (!cr_ff[OW-1] || acc_le0)) begin
                        result_ff <= 1'b1;
                        state_ff  <= S_OUT;
                     end else begin
                        state_ff <= R_BDOT;
                     end
                  end
                  R_BDOT: begin dot_ff <= OW'(mac_acc); state_ff <= R_BLEN; end
                  R_BLEN: begin len_ff <= OW'(mac_acc); state_ff <= R_BCR; end
                  R_BCR:  begin cr_ff  <= OW'(mac_acc); state_ff <= R_BCMP; end
                  R_BCMP: begin
                     if (!dot_ff[OW-1] && (dot_ff <= len_ff) && ((cr_ff <= 0) || acc_le0)) begin
                        result_ff <= 1'b1;
                        state_ff  <= S_OUT;
                     end else begin
                        state_ff <= R_C3X;
                     end
                  end
                  R_C3X: begin c3x_ff <= PW'(sc); state_ff <= R_C3Y; end
                  R_C3Y: begin c3y_ff <= PW'(sc); state_ff <= R_D3; end
                  R_D3, R_D4: begin
                     if (acc_lt0) begin
                        if (state_ff == R_D3) begin
                           c2x_ff <= c1x_ff;
                           c2y_ff <= c1y_ff;
                        end else begin
                           c0x_ff <= c1x_ff;
                           c0y_ff <= c1y_ff;
                        end
                        if (t_ff == LAST_ROUND) begin
                           result_ff <= 1'b0;
                           state_ff  <= S_OUT;
                        end else begin
                           t_ff     <= t_ff + 3'd1;
                           state_ff <= R_C1X;
                        end
                     end else begin
                        state_ff <= (state_ff == R_D3) ? R_D4 : R_ELEN;
                     end
                  end
                  R_ELEN: begin len_ff <= OW'(mac_acc); state_ff <= R_ECR; end
                  R_ECR:  begin cr_ff  <= OW'(mac_acc); state_ff <= R_ECMP; end
                  R_ECMP: begin
                     if ((cr_ff <= 0) || acc_lt0) begin
                        state_ff <= R_EDOT;
                     end else begin
                        result_ff <= 1'b0;
                        state_ff  <= S_OUT;
                     end
                  end
                  R_EDOT, R_F, R_G: begin
                     // keep the inner half (c2 := c1) or the outer half (c0 := c1)
                     if ((state_ff == R_EDOT) && (mac_acc > 0) && (mac_acc > AW'(len_ff))) begin
                        state_ff <= R_F;
                     end else if ((state_ff == R_EDOT) && (mac_acc <= 0) &&
                                  (mac_acc < -AW'(len_ff))) begin
                        state_ff <= R_G;
                     end else if ((state_ff != R_EDOT) && acc_lt0) begin
                        result_ff <= 1'b0;
                        state_ff  <= S_OUT;
                     end else begin
                        if ((state_ff == R_F) || ((state_ff == R_EDOT) && (mac_acc > 0))) begin
                           c2x_ff <= c1x_ff;
                           c2y_ff <= c1y_ff;
                        end else begin
                           c0x_ff <= c1x_ff;
                           c0y_ff <= c1y_ff;
                        end
                        if (t_ff == LAST_ROUND) begin
                           result_ff <= 1'b0;
                           state_ff  <= S_OUT;
                        end else begin
                           t_ff     <= t_ff + 3'd1;
                           state_ff <= R_C1X;
                        end
                     end
                  end
                  default: state_ff <= S_IDLE;
               endcase
            end
         end
      endcase
      if (reset) begin
         state_ff  <= S_IDLE;
         last_ff   <= S_IDLE;
         result_ff <= 1'b0;
         t_ff      <= '0;
      end
   end

   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = (state_ff == S_OUT);
   assign rsp.overlap = result_ff;

endmodule
